@@ sv/tssr_pkg.sv @@
// Shared types, codes and helpers for the token stream spacing renderer.
package tssr_pkg;

    // Input op codes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_EMPTY = 2'd1;
    localparam logic [1:0] OP_EOS   = 2'd2;

    // Token kinds
    localparam logic [2:0] KIND_OTHER  = 3'd0;
    localparam logic [2:0] KIND_PUNCT  = 3'd1;
    localparam logic [2:0] KIND_STRING = 3'd2;
    localparam logic [2:0] KIND_CHAR   = 3'd3;
    localparam logic [2:0] KIND_NUMBER = 3'd4;

    // Characters
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    // Input beat
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] text_byte;
        logic       first_of_token;
        logic [2:0] token_kind;
        logic       starts_line;
        logic       has_space;
    } t_in_beat;

    // Output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_beat;

    // Queue entry: one or two output bytes caused by one input beat
    typedef struct packed {
        logic       two_beats;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_q_entry;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_head;

    // Identifier character: A-Z, a-z, 0-9, underscore
    function automatic logic is_ident(input logic [7:0] c);
        is_ident = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
    endfunction

endpackage

@@ sv/token_stream_spacing_renderer_core.sv @@
// Top level of the token stream spacing renderer: front end, queue, back end.
//
//  Channel | Direction | Handshake                  | Beat
//  in      | input     | i_in_valid / o_in_stall    | t_in_beat (op, byte, token flags)
//  out     | output    | o_out_valid / i_out_stall  | t_out_beat (out_byte, last)
//
// One input beat is taken per cycle while the queue has room; the front end
// classifies it in the same cycle it is accepted.
// Each input beat yields zero, one or two output beats; the back end sends one
// per cycle while i_out_stall is low, so a separator costs one extra output beat.
// Reset is synchronous, active low; it clears the token state and empties the queue.
// A stalled output holds its beat; the queue absorbs up to DEPTH entries before
// o_in_stall rises.
module token_stream_spacing_renderer_core #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tssr_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tssr_pkg::t_out_beat o_out_data
);
    import tssr_pkg::*;

    logic     q_full;
    logic     push;
    t_q_entry push_entry;
    logic     pop;
    t_q_head  head;

    tssr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_push_entry (push_entry)
    );

    tssr_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_entry (push_entry),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head       (head)
    );

    tssr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

@@ sv/tssr_front.sv @@
// Front end: accepts input beats, picks the separator and builds queue entries.
module tssr_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tssr_pkg::t_in_beat i_in_data,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output tssr_pkg::t_q_entry o_push_entry
);
    import tssr_pkg::*;

    logic       r_started;
    logic [2:0] r_prev_kind;
    logic [7:0] r_prev_last;
    logic       r_prev_empty;
    logic       n_started;
    logic [2:0] n_prev_kind;
    logic [7:0] n_prev_last;
    logic       n_prev_empty;

    logic       accept;
    logic       tok_start;
    logic       hazard;
    logic       sep_v;
    logic [7:0] sep;
    logic [7:0] a;
    logic [7:0] b;
    logic [2:0] kind;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign a          = r_prev_last;
    assign b          = i_in_data.text_byte;
    assign kind       = i_in_data.token_kind;

    // Gluing hazard between previous token and current first byte
    always_comb begin
        hazard = 1'b0;
        if (!r_prev_empty) begin
            if (is_ident(a) && is_ident(b))                             hazard = 1'b1;
            if (r_prev_kind == KIND_PUNCT && kind == KIND_PUNCT)          hazard = 1'b1;
            if ((kind == KIND_STRING || kind == KIND_CHAR) && is_ident(a)) hazard = 1'b1;
            if (r_prev_kind == KIND_NUMBER &&
                (b == CH_DOT || b == CH_PLUS || b == CH_MINUS))          hazard = 1'b1;
            if (a == CH_DOT && kind == KIND_NUMBER)                       hazard = 1'b1;
        end
    end

    // Separator choice at a token start
    always_comb begin
        sep_v = 1'b0;
        sep   = CH_SPACE;
        if (r_started) begin
            if (i_in_data.starts_line) begin
                sep_v = 1'b1;
                sep   = CH_NEWLINE;
            end else if (i_in_data.has_space ||
                         (i_in_data.op == OP_BYTE && hazard)) begin
                sep_v = 1'b1;
                sep   = CH_SPACE;
            end
        end
    end

    assign tok_start = (i_in_data.op == OP_BYTE && (i_in_data.first_of_token || !r_started)) ||
                       (i_in_data.op == OP_EMPTY);

    // Entry build and state update
    always_comb begin
        o_push       = 1'b0;
        o_push_entry = '{two_beats: 1'b0, b0: b, b1: b};
        n_started    = r_started;
        n_prev_kind  = r_prev_kind;
        n_prev_last  = r_prev_last;
        n_prev_empty = r_prev_empty;
        unique case (i_in_data.op)
            OP_BYTE: begin
                o_push = accept;
                if (tok_start) begin
                    n_started   = 1'b1;
                    n_prev_kind = kind;
                    if (sep_v) begin
                        o_push_entry = '{two_beats: 1'b1, b0: sep, b1: b};
                    end
                end
                n_prev_last  = b;
                n_prev_empty = 1'b0;
            end
            OP_EMPTY: begin
                o_push       = accept && sep_v;
                o_push_entry = '{two_beats: 1'b0, b0: sep, b1: sep};
                n_started    = 1'b1;
                n_prev_kind  = kind;
                n_prev_empty = 1'b1;
            end
            OP_EOS: begin
                o_push       = accept && r_started;
                o_push_entry = '{two_beats: 1'b0, b0: CH_NEWLINE, b1: CH_NEWLINE};
                n_started    = 1'b0;
                n_prev_kind  = KIND_OTHER;
                n_prev_last  = 8'h00;
                n_prev_empty = 1'b1;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_prev_kind  <= KIND_OTHER;
            r_prev_last  <= 8'h00;
            r_prev_empty <= 1'b1;
        end else if (accept) begin
            r_started    <= n_started;
            r_prev_kind  <= n_prev_kind;
            r_prev_last  <= n_prev_last;
            r_prev_empty <= n_prev_empty;
        end
    end

endmodule

@@ sv/tssr_queue.sv @@
// Small FIFO of pending output entries between front and back ends.
module tssr_queue #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  tssr_pkg::t_q_entry i_push_entry,
    input  logic               i_pop,
    output logic               o_full,
    output tssr_pkg::t_q_head  o_head
);
    import tssr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_q_entry        r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    // Pointer wrap
    assign n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= n_wr_ptr;
            if (do_pop)  r_rd_ptr <= n_rd_ptr;
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head.valid)
        else $error("pop from empty queue");

endmodule

@@ sv/tssr_back.sv @@
// Back end: drains queue entries as one or two output beats.
module tssr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tssr_pkg::t_q_head   i_head,
    input  logic                i_out_stall,
    output logic                o_pop,
    output logic                o_out_valid,
    output tssr_pkg::t_out_beat o_out_data
);
    import tssr_pkg::*;

    logic r_phase;
    logic first_of_two;
    logic beat_done;

    assign o_out_valid  = i_head.valid;
    assign first_of_two = i_head.entry.two_beats && !r_phase;
    assign beat_done    = o_out_valid && !i_out_stall;
    assign o_pop        = beat_done && !first_of_two;

    // Beat select
    always_comb begin
        o_out_data.last     = !first_of_two;
        o_out_data.out_byte = (i_head.entry.two_beats && r_phase) ? i_head.entry.b1
                                                                  : i_head.entry.b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (beat_done) begin
            r_phase <= first_of_two;
        end
    end

    a_phase_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (i_head.valid && i_head.entry.two_beats))
        else $error("second phase without a two-beat entry");

    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat_done && !o_out_data.last) |=> (o_out_valid && o_out_data.last))
        else $error("first beat not followed by last beat");

    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> o_out_data.last)
        else $error("entry popped before its last beat");

endmodule
